@@ hw/rtl/vpp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpp_pkg
// shared constants, codes, types and helper functions of the host port
// ----------------------------------------------------------------------------
package vpp_pkg;

    // video ram depth, 4096 to 16384 entries
    localparam int VRAM_DEPTH = 16384;
    localparam int ADDR_W     = 14;
    localparam int RAM_AW     = $clog2(VRAM_DEPTH);

    // access kinds carried on the input tuser
    localparam logic [2:0] MODE_CTRL_WR = 3'd0;
    localparam logic [2:0] MODE_DATA_WR = 3'd1;
    localparam logic [2:0] MODE_DATA_RD = 3'd2;
    localparam logic [2:0] MODE_STAT_RD = 3'd3;
    localparam logic [2:0] MODE_RETRACE = 3'd4;

    // register holding the interrupt enable
    localparam logic [2:0] REG_IRQ_CTRL = 3'd1;
    localparam int         IE_BIT       = 5;

    // controller to datapath commands
    typedef struct packed {
        logic clear;
        logic exec;
        logic fill;
        logic emit;
    } vpp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clear_done;
        logic need_fetch;
    } vpp_status_t;

    // per register write mask
    function automatic logic [7:0] reg_mask(input logic [2:0] r);
        logic [7:0] m;
        case (r)
            3'd2:    m = 8'h0F;
            3'd4:    m = 8'h07;
            3'd5:    m = 8'h7F;
            3'd6:    m = 8'h07;
            default: m = 8'hFF;
        endcase
        return m;
    endfunction

    // 14-bit address folded onto the ram depth, at most three subtractions
    function automatic logic [RAM_AW-1:0] ram_index(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W:0] a;
        a = {1'b0, addr};
        for (int i = 0; i < 4; i++) begin
            if (a >= (ADDR_W+1)'(VRAM_DEPTH)) begin
                a = a - (ADDR_W+1)'(VRAM_DEPTH);
            end
        end
        return a[RAM_AW-1:0];
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/vpp_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpp_ctrl
// sequencer: ram clearing, accept, optional prefetch cycle, result hand-off
// ----------------------------------------------------------------------------
module vpp_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire vpp_pkg::vpp_status_t status,
    output vpp_pkg::vpp_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_EMIT
    } state_t;

    state_t state_reg;
    logic   s_tready_reg;
    logic   m_tvalid_reg;

    assign s_tready  = s_tready_reg;
    assign m_tvalid  = m_tvalid_reg;

    assign cmd.clear = (state_reg == ST_CLEAR);
    assign cmd.exec  = s_tvalid && s_tready_reg;
    assign cmd.fill  = (state_reg == ST_FETCH);
    assign cmd.emit  = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            s_tready_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // a new result in the same cycle keeps valid up
            if (m_tvalid_reg && m_tready && !cmd.emit)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    if (status.clear_done)
                    begin
                        state_reg    <= ST_IDLE;
                        s_tready_reg <= 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    if (cmd.exec)
                    begin
                        s_tready_reg <= 1'b0;
                        state_reg    <= status.need_fetch ? ST_FETCH : ST_EMIT;
                    end
                end
                ST_FETCH:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (cmd.emit)
                    begin
                        m_tvalid_reg <= 1'b1;
                        s_tready_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_CLEAR;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/vpp_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpp_datapath
// video ram, address pointer, command latch, read-ahead, status and registers
// ----------------------------------------------------------------------------
module vpp_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire vpp_pkg::vpp_cmd_t  cmd,
    output vpp_pkg::vpp_status_t    status,
    input  wire logic [2:0]         mode,
    input  wire logic [7:0]         bus_byte,
    input  wire logic               collision_seen,
    input  wire logic               overflow_seen,
    input  wire logic [4:0]         overflow_sprite,
    output logic [7:0]              read_byte,
    output logic                    irq_line
);

    logic [7:0] video_ram [vpp_pkg::VRAM_DEPTH];

    logic [vpp_pkg::ADDR_W-1:0] vram_pointer_reg;
    logic [7:0]                 first_byte_reg;
    logic                       awaiting_second_reg;
    logic [7:0]                 prefetch_reg;
    logic [7:0]                 status_byte_reg;
    logic [7:0]                 control_regs_reg [8];
    logic                       frame_refreshed_reg;
    logic                       lat_collision_reg;
    logic                       lat_overflow_reg;
    logic [4:0]                 lat_sprite_reg;
    logic                       irq_pending_reg;
    logic [7:0]                 res_byte_reg;
    logic [7:0]                 ram_q_reg;
    logic [7:0]                 out_byte_reg;
    logic                       out_irq_reg;
    logic [vpp_pkg::RAM_AW-1:0] clr_idx_reg;
    logic                       clear_done_reg;

    logic [vpp_pkg::ADDR_W-1:0] set_addr;
    logic [vpp_pkg::ADDR_W-1:0] rd_addr;
    logic [7:0]                 reg_value;
    logic [7:0]                 status_merged;
    logic                       is_second;

    assign is_second = (mode == vpp_pkg::MODE_CTRL_WR) && awaiting_second_reg;
    assign set_addr  = {bus_byte[5:0], first_byte_reg};
    assign rd_addr   = (mode == vpp_pkg::MODE_CTRL_WR) ? set_addr : vram_pointer_reg;
    assign reg_value = first_byte_reg & vpp_pkg::reg_mask(bus_byte[2:0]);
    assign status_merged = status_byte_reg
                         | (frame_refreshed_reg
                            ? {1'b0, lat_overflow_reg, lat_collision_reg, lat_sprite_reg}
                            : 8'h00);

    assign status.clear_done = clear_done_reg;
    assign status.need_fetch = (mode == vpp_pkg::MODE_DATA_RD)
                             || (is_second && !bus_byte[7] && !bus_byte[6]);

    assign read_byte = out_byte_reg;
    assign irq_line  = out_irq_reg;

    // ram: clearing sweep or data write, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.clear && !clear_done_reg)
        begin
            video_ram[clr_idx_reg] <= 8'h00;
        end
        else if (cmd.exec && (mode == vpp_pkg::MODE_DATA_WR))
        begin
            video_ram[vpp_pkg::ram_index(vram_pointer_reg)] <= bus_byte;
        end
        ram_q_reg <= video_ram[vpp_pkg::ram_index(rd_addr)];
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_byte_reg <= res_byte_reg;
            out_irq_reg  <= irq_pending_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vram_pointer_reg    <= '0;
            first_byte_reg      <= '0;
            awaiting_second_reg <= 1'b0;
            prefetch_reg        <= '0;
            status_byte_reg     <= '0;
            for (int i = 0; i < 8; i++)
            begin
                control_regs_reg[i] <= '0;
            end
            frame_refreshed_reg <= 1'b0;
            lat_collision_reg   <= 1'b0;
            lat_overflow_reg    <= 1'b0;
            lat_sprite_reg      <= '0;
            irq_pending_reg     <= 1'b0;
            res_byte_reg        <= '0;
            clr_idx_reg         <= '0;
            clear_done_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.clear && !clear_done_reg)
            begin
                if (clr_idx_reg == vpp_pkg::RAM_AW'(vpp_pkg::VRAM_DEPTH - 1))
                begin
                    clear_done_reg <= 1'b1;
                end
                else
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                end
            end

            // second half of a read-ahead
            if (cmd.fill)
            begin
                prefetch_reg     <= ram_q_reg;
                vram_pointer_reg <= vram_pointer_reg + 1'b1;
            end

            if (cmd.exec)
            begin
                res_byte_reg <= 8'h00;
                case (mode)
                    vpp_pkg::MODE_CTRL_WR:
                    begin
                        if (!awaiting_second_reg)
                        begin
                            first_byte_reg      <= bus_byte;
                            awaiting_second_reg <= 1'b1;
                        end
                        else
                        begin
                            awaiting_second_reg <= 1'b0;
                            if (bus_byte[7])
                            begin
                                control_regs_reg[bus_byte[2:0]] <= reg_value;
                                if ((bus_byte[2:0] == vpp_pkg::REG_IRQ_CTRL)
                                    && reg_value[vpp_pkg::IE_BIT] && status_byte_reg[7])
                                begin
                                    irq_pending_reg <= 1'b1;
                                end
                            end
                            else
                            begin
                                vram_pointer_reg <= set_addr;
                            end
                        end
                    end
                    vpp_pkg::MODE_DATA_WR:
                    begin
                        awaiting_second_reg <= 1'b0;
                        vram_pointer_reg    <= vram_pointer_reg + 1'b1;
                    end
                    vpp_pkg::MODE_DATA_RD:
                    begin
                        awaiting_second_reg <= 1'b0;
                        res_byte_reg        <= prefetch_reg;
                    end
                    vpp_pkg::MODE_STAT_RD:
                    begin
                        awaiting_second_reg <= 1'b0;
                        frame_refreshed_reg <= 1'b0;
                        res_byte_reg        <= status_merged;
                        status_byte_reg     <= 8'h00;
                        irq_pending_reg     <= 1'b0;
                    end
                    vpp_pkg::MODE_RETRACE:
                    begin
                        frame_refreshed_reg <= 1'b1;
                        lat_collision_reg   <= collision_seen;
                        lat_overflow_reg    <= overflow_seen;
                        lat_sprite_reg      <= overflow_sprite;
                        status_byte_reg[7]  <= 1'b1;
                        if (control_regs_reg[vpp_pkg::REG_IRQ_CTRL][vpp_pkg::IE_BIT])
                        begin
                            irq_pending_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/video_processor_host_port.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// video_processor_host_port
// host bus side of a video display processor: control latch, registers,
// vram access with auto-increment and read-ahead, status and interrupt
// ----------------------------------------------------------------------------
//  channel   direction  tuser            tdata
//  s_*       in         [2:0] mode       [7:0] bus_byte, [8] collision_seen,
//                                        [9] overflow_seen, [14:10] overflow_sprite
//  m_*       out        -                [7:0] read_byte, [8] irq_line
//
//  one beat in gives one beat out; an access goes from accept through an optional
//  fetch state, which refills the read-ahead byte from the registered vram read
//  port, to the emit state that registers the result
//  after reset the vram is swept to zero, one entry a cycle, with s_tready low
//  a result waiting on m_tready lets one more beat in, which then waits in
//  its result step with s_tready low
// ----------------------------------------------------------------------------
module video_processor_host_port (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // bus_byte, collision_seen, overflow_seen, overflow_sprite
    input  wire logic [2:0]  s_tuser,   // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // read_byte, irq_line
);

    vpp_pkg::vpp_cmd_t    cmd;
    vpp_pkg::vpp_status_t status;
    logic [7:0]           read_byte;
    logic                 irq_line;

    // sequencer: clearing, accept, read-ahead cycle, result hand-off
    vpp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // data state of the port: vram, pointer, latch, registers, status and interrupt
    vpp_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .mode            (s_tuser),
        .bus_byte        (s_tdata[7:0]),
        .collision_seen  (s_tdata[8]),
        .overflow_seen   (s_tdata[9]),
        .overflow_sprite (s_tdata[14:10]),
        .read_byte       (read_byte),
        .irq_line        (irq_line)
    );

    assign m_tdata = {7'b0, irq_line, read_byte};

`ifndef ASSERT_OFF
    // no beat is taken before the vram sweep has finished
    assert property (@(posedge clk) disable iff (!rst_n)
        !status.clear_done |-> !s_tready)
        else $error("input accepted during vram clearing");

    // one access at a time: ready drops right after a beat is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second beat accepted while an access is in flight");

    // a read-ahead never runs while the port is ready for a new beat or hands off a result
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill |-> (!s_tready && !cmd.emit))
        else $error("read-ahead overlaps accept or result");
`endif

endmodule
`default_nettype wire

@@ tb/video_processor_host_port_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_processor_host_port_test
// self-checking bench for the host port: a queue-fed beat driver, a result
// monitor and a per-beat predictor of the vram, latch, status and irq
// ----------------------------------------------------------------------------
module video_processor_host_port_test;

    // run shaping
    localparam int RANDOM_ITEMS  = 850;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int QUIET_FIRST   = 450;
    localparam int QUIET_LAST    = 600;
    localparam int HOLDOFF_AT    = 300;
    localparam int HOLDOFF_LEN   = 120;
    localparam int IDLE_PERCENT  = 9;
    localparam int DRAIN_CYCLES  = 10;

    // status byte layout
    localparam logic [7:0] STAT_FRAME  = 8'h80;
    localparam logic [7:0] STAT_FIFTH  = 8'h40;
    localparam logic [7:0] STAT_COLL   = 8'h20;
    localparam logic [7:0] STAT_SPRITE = 8'h1F;

    // second control byte: bit 7 selects a register write, bit 6 skips read-ahead
    localparam logic [7:0] CTRL_REG_SEL  = 8'h80;
    localparam logic [7:0] CTRL_NO_FETCH = 8'h40;

    localparam logic [7:0] REG_MASKS [8] = '{8'hFF, 8'hFF, 8'h0F, 8'hFF,
                                             8'h07, 8'h7F, 8'h07, 8'hFF};

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] bus_byte;
        logic       collision_seen;
        logic       overflow_seen;
        logic [4:0] overflow_sprite;
    } host_access_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       irq_line;
    } port_reply_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // bus_byte, collision_seen, overflow_seen, overflow_sprite
    logic [2:0]  s_tuser  = '0;     // mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // read_byte, irq_line

    video_processor_host_port uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predicted state of the port
    // ------------------------------------------------------------------------
    logic [7:0]  shadow_vram [vpp_pkg::VRAM_DEPTH];
    logic [13:0] shadow_addr;
    logic [7:0]  shadow_first_byte;
    logic        shadow_second_due;
    logic [7:0]  shadow_readahead;
    logic [7:0]  shadow_status;
    logic [7:0]  shadow_regs [8];
    logic        shadow_frame_new;
    logic        shadow_coll;
    logic        shadow_fifth;
    logic [4:0]  shadow_sprite;
    logic        shadow_irq;

    // beats waiting to go out, and replies the port still owes
    host_access_t bus_accesses_queued [$];
    port_reply_t  port_replies_due [$];
    logic [13:0]  written_bases [$];

    host_access_t beat_on_bus;
    port_reply_t  reply_want;
    int beats_queued    = 0;
    int items_counted   = 0;
    int beats_accepted  = 0;
    int replies_checked = 0;
    int error_count     = 0;
    int cycle_count     = 0;
    int holdoff_left    = 0;
    bit holdoff_done    = 1'b0;

    // vram entry behind a 14-bit address, folded for a smaller memory
    function automatic int vram_slot(input logic [13:0] addr);
        return int'(addr) % vpp_pkg::VRAM_DEPTH;
    endfunction

    // apply one accepted beat to the shadow state and return the reply it owes
    function automatic port_reply_t predict_reply(input host_access_t acc);
        port_reply_t rep;
        logic [2:0]  reg_sel;
        logic [7:0]  value;
        rep.read_byte = 8'h00;
        case (acc.mode)
            vpp_pkg::MODE_CTRL_WR:
            begin
                if (!shadow_second_due)
                begin
                    shadow_first_byte = acc.bus_byte;
                    shadow_second_due = 1'b1;
                end
                else
                begin
                    shadow_second_due = 1'b0;
                    if ((acc.bus_byte & CTRL_REG_SEL) != 0)
                    begin
                        reg_sel = acc.bus_byte[2:0];
                        value   = shadow_first_byte & REG_MASKS[reg_sel];
                        shadow_regs[reg_sel] = value;
                        // enabling with the frame flag up raises the line at once
                        if (reg_sel == vpp_pkg::REG_IRQ_CTRL && value[vpp_pkg::IE_BIT]
                            && (shadow_status & STAT_FRAME) != 0)
                            shadow_irq = 1'b1;
                    end
                    else
                    begin
                        shadow_addr = {acc.bus_byte[5:0], shadow_first_byte};
                        if ((acc.bus_byte & CTRL_NO_FETCH) == 0)
                        begin
                            shadow_readahead = shadow_vram[vram_slot(shadow_addr)];
                            shadow_addr      = shadow_addr + 14'd1;
                        end
                    end
                end
            end
            vpp_pkg::MODE_DATA_WR:
            begin
                shadow_second_due = 1'b0;
                shadow_vram[vram_slot(shadow_addr)] = acc.bus_byte;
                shadow_addr = shadow_addr + 14'd1;
            end
            vpp_pkg::MODE_DATA_RD:
            begin
                shadow_second_due = 1'b0;
                rep.read_byte     = shadow_readahead;
                shadow_readahead  = shadow_vram[vram_slot(shadow_addr)];
                shadow_addr       = shadow_addr + 14'd1;
            end
            vpp_pkg::MODE_STAT_RD:
            begin
                shadow_second_due = 1'b0;
                // sprite flags join the status only on the first read after retrace
                if (shadow_frame_new)
                begin
                    shadow_frame_new = 1'b0;
                    if (shadow_coll)
                        shadow_status = shadow_status | STAT_COLL;
                    if (shadow_fifth)
                        shadow_status = shadow_status | STAT_FIFTH;
                    shadow_status = shadow_status | ({3'b000, shadow_sprite} & STAT_SPRITE);
                end
                rep.read_byte = shadow_status;
                shadow_status = 8'h00;
                shadow_irq    = 1'b0;
            end
            vpp_pkg::MODE_RETRACE:
            begin
                shadow_frame_new = 1'b1;
                shadow_coll      = acc.collision_seen;
                shadow_fifth     = acc.overflow_seen;
                shadow_sprite    = acc.overflow_sprite;
                shadow_status    = shadow_status | STAT_FRAME;
                if (shadow_regs[vpp_pkg::REG_IRQ_CTRL][vpp_pkg::IE_BIT])
                    shadow_irq = 1'b1;
            end
            default:
            begin
            end
        endcase
        rep.irq_line = shadow_irq;
        return rep;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------------
    task automatic queue_beat(input logic [2:0] mode, input logic [7:0] data,
                              input logic coll, input logic fifth, input logic [4:0] spr);
        host_access_t acc;
        acc.mode            = mode;
        acc.bus_byte        = data;
        acc.collision_seen  = coll;
        acc.overflow_seen   = fifth;
        acc.overflow_sprite = spr;
        bus_accesses_queued.push_back(acc);
        beats_queued++;
        // unused modes leave the port state alone and do not count
        if (mode <= vpp_pkg::MODE_RETRACE)
            items_counted++;
    endtask

    // sprite fields random on every beat, they only matter on retrace
    task automatic queue_access(input logic [2:0] mode, input logic [7:0] data);
        queue_beat(mode, data, 1'($urandom), 1'($urandom), 5'($urandom));
    endtask

    // start addresses: ones already written, around the wrap point, near zero or random
    function automatic logic [13:0] pick_address();
        int roll;
        roll = $urandom_range(99);
        if (roll < 35 && written_bases.size() != 0)
            return written_bases[$urandom_range(written_bases.size() - 1)];
        if (roll < 60)
            return 14'h3FF0 + 14'($urandom_range(15));
        if (roll < 70)
            return 14'($urandom_range(15));
        return 14'($urandom);
    endfunction

    task automatic queue_random_session();
        int          kind;
        int          burst;
        logic [13:0] base;
        logic [7:0]  second;
        kind = $urandom_range(99);
        if (kind < 18)
        begin
            // register write, interrupt control register favored
            second = {1'b1, 4'($urandom), 3'($urandom)};
            if ($urandom_range(99) < 35)
                second[2:0] = vpp_pkg::REG_IRQ_CTRL;
            queue_access(vpp_pkg::MODE_CTRL_WR, 8'($urandom));
            queue_access(vpp_pkg::MODE_CTRL_WR, second);
        end
        else if (kind < 38)
        begin
            // write burst
            base  = pick_address();
            burst = $urandom_range(1, 8);
            written_bases.push_back(base);
            if (written_bases.size() > 16)
                void'(written_bases.pop_front());
            queue_access(vpp_pkg::MODE_CTRL_WR, base[7:0]);
            queue_access(vpp_pkg::MODE_CTRL_WR, {2'b01, base[13:8]});
            repeat (burst)
                queue_access(vpp_pkg::MODE_DATA_WR, 8'($urandom));
        end
        else if (kind < 58)
        begin
            // read burst, now and then set up without read-ahead
            base   = pick_address();
            burst  = $urandom_range(1, 8);
            second = {2'b00, base[13:8]};
            if ($urandom_range(99) < 15)
                second = second | CTRL_NO_FETCH;
            queue_access(vpp_pkg::MODE_CTRL_WR, base[7:0]);
            queue_access(vpp_pkg::MODE_CTRL_WR, second);
            repeat (burst)
                queue_access(vpp_pkg::MODE_DATA_RD, 8'($urandom));
        end
        else if (kind < 70)
        begin
            queue_access(vpp_pkg::MODE_RETRACE, 8'($urandom));
            repeat ($urandom_range(0, 2))
                queue_access(vpp_pkg::MODE_STAT_RD, 8'($urandom));
        end
        else if (kind < 78)
        begin
            queue_access(vpp_pkg::MODE_STAT_RD, 8'($urandom));
        end
        else if (kind < 88)
        begin
            // first control byte followed by another access, which cuts it off unless it is a retrace
            queue_access(vpp_pkg::MODE_CTRL_WR, 8'($urandom));
            queue_access(3'($urandom_range(vpp_pkg::MODE_DATA_WR, vpp_pkg::MODE_RETRACE)),
                         8'($urandom));
            if ($urandom_range(1) == 1)
                queue_access(vpp_pkg::MODE_CTRL_WR, 8'($urandom));
        end
        else
        begin
            // noise, unused modes included
            queue_access(3'($urandom_range(7)), 8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: one beat held on the bus until accepted
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                port_replies_due.push_back(predict_reply(beat_on_bus));
                beats_accepted <= beats_accepted + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                // no idling inside the quiet window
                if (bus_accesses_queued.size() != 0
                    && ((beats_accepted >= QUIET_FIRST && beats_accepted < QUIET_LAST)
                        || $urandom_range(99) >= IDLE_PERCENT))
                begin
                    beat_on_bus = bus_accesses_queued.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, beat_on_bus.overflow_sprite, beat_on_bus.overflow_seen,
                                 beat_on_bus.collision_seen, beat_on_bus.bus_byte};
                    s_tuser  <= beat_on_bus.mode;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random back-pressure plus one long hold-off to fill the port
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            holdoff_left <= 0;
        end
        else if (holdoff_left != 0)
        begin
            m_tready     <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end
        else if (!holdoff_done && replies_checked >= HOLDOFF_AT)
        begin
            holdoff_done <= 1'b1;
            holdoff_left <= HOLDOFF_LEN;
            m_tready     <= 1'b0;
        end
        else
        begin
            m_tready <= (replies_checked >= QUIET_FIRST && replies_checked < QUIET_LAST)
                        || $urandom_range(99) >= IDLE_PERCENT;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: every result beat against the oldest predicted reply
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            replies_checked <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            replies_checked <= replies_checked + 1;
            if (port_replies_due.size() == 0)
            begin
                $error("result beat with nothing expected, tdata %h", m_tdata);
                error_count++;
            end
            else
            begin
                reply_want = port_replies_due.pop_front();
                if (m_tdata[7:0] !== reply_want.read_byte)
                begin
                    $error("read_byte expected %h actual %h", reply_want.read_byte,
                           m_tdata[7:0]);
                    error_count++;
                end
                if (m_tdata[8] !== reply_want.irq_line)
                begin
                    $error("irq_line expected %b actual %b", reply_want.irq_line, m_tdata[8]);
                    error_count++;
                end
            end
        end
    end

    // watchdog, covers the vram sweep after reset with a wide margin
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL video_processor_host_port");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sequence: reset, directed beats, full drain, random sessions, drain
    // ------------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < vpp_pkg::VRAM_DEPTH; i++)
            shadow_vram[i] = 8'h00;
        for (int i = 0; i < 8; i++)
            shadow_regs[i] = 8'h00;
        shadow_addr       = '0;
        shadow_first_byte = '0;
        shadow_second_due = 1'b0;
        shadow_readahead  = '0;
        shadow_status     = '0;
        shadow_frame_new  = 1'b0;
        shadow_coll       = 1'b0;
        shadow_fifth      = 1'b0;
        shadow_sprite     = '0;
        shadow_irq        = 1'b0;

        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // status and read-ahead straight after reset
        queue_beat(vpp_pkg::MODE_STAT_RD, 8'h00, 1'b0, 1'b0, 5'd0);
        queue_beat(vpp_pkg::MODE_DATA_RD, 8'h00, 1'b0, 1'b0, 5'd0);
        // interrupt enable while the frame flag is clear: line stays low
        queue_beat(vpp_pkg::MODE_CTRL_WR, 8'hFF, 1'b0, 1'b0, 5'd0);
        queue_beat(vpp_pkg::MODE_CTRL_WR, 8'h81, 1'b0, 1'b0, 5'd0);
        // retrace with every sprite flag, then the merge on the first status read only
        queue_beat(vpp_pkg::MODE_RETRACE, 8'h00, 1'b1, 1'b1, 5'd31);
        queue_beat(vpp_pkg::MODE_STAT_RD, 8'h00, 1'b0, 1'b0, 5'd0);
        queue_beat(vpp_pkg::MODE_STAT_RD, 8'h00, 1'b0, 1'b0, 5'd0);
        // retrace with interrupts off, then enabling raises the line late
        queue_beat(vpp_pkg::MODE_CTRL_WR, 8'h00, 1'b0, 1'b0, 5'd0);
        queue_beat(vpp_pkg::MODE_CTRL_WR, 8'h81, 1'b0, 1'b0, 5'd0);
        queue_beat(vpp_pkg::MODE_RETRACE, 8'h00, 1'b0, 1'b0, 5'd0);
        queue_beat(vpp_pkg::MODE_CTRL_WR, 8'h20, 1'b0, 1'b0, 5'd0);
        queue_beat(vpp_pkg::MODE_CTRL_WR, 8'h81, 1'b0, 1'b0, 5'd0);
        // disabling leaves the line up until a status read
        queue_beat(vpp_pkg::MODE_CTRL_WR, 8'h00, 1'b0, 1'b0, 5'd0);
        queue_beat(vpp_pkg::MODE_CTRL_WR, 8'h81, 1'b0, 1'b0, 5'd0);
        queue_beat(vpp_pkg::MODE_STAT_RD, 8'h00, 1'b0, 1'b0, 5'd0);
        // writes across the top of the address space
        queue_beat(vpp_pkg::MODE_CTRL_WR, 8'hFF, 1'b0, 1'b0, 5'd0);
        queue_beat(vpp_pkg::MODE_CTRL_WR, 8'h7F, 1'b0, 1'b0, 5'd0);
        queue_beat(vpp_pkg::MODE_DATA_WR, 8'hA5, 1'b0, 1'b0, 5'd0);
        queue_beat(vpp_pkg::MODE_DATA_WR, 8'h5A, 1'b0, 1'b0, 5'd0);
        // read back across the wrap
        queue_beat(vpp_pkg::MODE_CTRL_WR, 8'hFF, 1'b0, 1'b0, 5'd0);
        queue_beat(vpp_pkg::MODE_CTRL_WR, 8'h3F, 1'b0, 1'b0, 5'd0);
        queue_beat(vpp_pkg::MODE_DATA_RD, 8'h00, 1'b0, 1'b0, 5'd0);
        queue_beat(vpp_pkg::MODE_DATA_RD, 8'h00, 1'b0, 1'b0, 5'd0);
        // unused mode with every bit set
        queue_beat(3'd7, 8'hFF, 1'b1, 1'b1, 5'd31);
        // retrace between the two control bytes keeps the latch: masked register write
        queue_beat(vpp_pkg::MODE_CTRL_WR, 8'hFF, 1'b0, 1'b0, 5'd0);
        queue_beat(vpp_pkg::MODE_RETRACE, 8'h00, 1'b0, 1'b1, 5'd5);
        queue_beat(vpp_pkg::MODE_CTRL_WR, 8'hC5, 1'b0, 1'b0, 5'd0);

        // sender pause: let every reply come home before the random part
        while (beats_accepted < beats_queued || port_replies_due.size() != 0)
            @(posedge clk);

        items_counted = 0;
        while (items_counted < RANDOM_ITEMS)
            queue_random_session();

        while (beats_accepted < beats_queued || port_replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("PASS video_processor_host_port");
        else
            $display("FAIL video_processor_host_port");
        $finish;
    end

endmodule
